FILE: rtl/core/eppip_pkg.sv
// Package for the Ethernet / PPPoE / IPv4 header parser.
// Holds protocol constants, field widths and the result word type.
// No dependencies.
package eppip_pkg;

   // frame limits
   localparam int unsigned MAX_FRAME_BYTES = 16384;
   localparam int unsigned OFFSET_W        = 16;

   // protocol codes
   localparam logic [15:0] ETYPE_PPPOE_SES = 16'h8864;
   localparam logic [15:0] ETYPE_IPV4      = 16'h0800;
   localparam logic [15:0] PPP_PROTO_IPV4  = 16'h0021;
   localparam logic [7:0]  PPPOE_CODE_SES  = 8'h00;
   localparam logic [8:0]  IP_PROTO_TCP    = 9'h006;
   localparam logic [8:0]  IP_PROTO_UDP    = 9'h011;
   localparam logic [8:0]  IP_PROTO_NONE   = 9'h100;
   localparam logic [7:0]  TS_SYNC_BYTE    = 8'h47;
   localparam logic [7:0]  RTP_V2_BYTE     = 8'h80;
   localparam logic [7:0]  TCP_FLAG_MASK   = 8'h3f;

   // header start offsets
   localparam logic [OFFSET_W-1:0] IP_BASE_ETH   = 16'd14;
   localparam logic [OFFSET_W-1:0] IP_BASE_PPPOE = 16'd22;

   // payload phase codes
   localparam logic [1:0] PH_WAIT   = 2'd0;
   localparam logic [1:0] PH_RTP    = 2'd1;
   localparam logic [1:0] PH_STREAM = 2'd2;
   localparam logic [1:0] PH_NONE   = 2'd3;

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam int unsigned RSP_DATA_W = 160;

   // one result word
   typedef struct packed {
      logic        kind;
      logic        last_of_run;
      logic [7:0]  payload_byte;
      logic [15:0] ether_type;
      logic [7:0]  pppoe_code;
      logic [15:0] pppoe_session;
      logic [8:0]  ip_protocol;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [5:0]  ctrl_flags;
   } result_type;

endpackage

FILE: rtl/core/eth_pppoe_ip_header_parser.sv
// Ethernet / PPPoE / IPv4 / TCP-UDP header parser, one frame byte per word.
// Depends on eppip_pkg; holds the capture logic and a four-word result queue.
//
// An accepted input word's result words enter the queue as the word is accepted.
// Throughput: one input word per cycle while the queue holds two words or fewer;
// a byte with both a payload word and the end-of-frame summary pushes both at once.
// Reset: synchronous, active high; clears frame state, queue and extract_mode.
module eth_pppoe_ip_header_parser (
   input  logic                               clock,
   input  logic                               reset,
   // input words
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // data_byte
   input  logic                               req_tlast,  // last_byte
   // result words
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // payload_byte, ether_type, pppoe_code, pppoe_session, ip_protocol,
   // src_ip, dst_ip, src_port, dst_port, ctrl_flags, one zero pad bit
   output logic [eppip_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                               rsp_tlast,  // last_of_run
   output logic                               rsp_tuser,  // kind
   // configuration
   input  logic                               csr_wr_en,
   input  logic                               csr_wr_data // extract_mode
);
   import eppip_pkg::*;

   // frame state
   logic                extract_mode_ff;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [15:0]         eth_type_ff, eth_type_in;
   logic [7:0]          pppoe_code_ff, pppoe_code_in;
   logic [15:0]         pppoe_ses_ff, pppoe_ses_in;
   logic [15:0]         ppp_proto_ff, ppp_proto_in;
   logic [3:0]          ihl_ff, ihl_in;
   logic [8:0]          ip_proto_ff, ip_proto_in;
   logic [31:0]         src_ip_ff, src_ip_in;
   logic [31:0]         dst_ip_ff, dst_ip_in;
   logic [31:0]         ports_ff, ports_in;
   logic [5:0]          flags_ff, flags_in;
   logic [1:0]          phase_ff, phase_in;

   // result queue
   result_type          queue_ff [4];
   logic [1:0]          wr_ptr_ff, wr_ptr_in;
   logic [1:0]          rd_ptr_ff, rd_ptr_in;
   logic [2:0]          count_ff, count_in;

   logic                accept, pop, emit;
   logic [7:0]          b;
   logic                ip_ok;
   logic [OFFSET_W-1:0] base, rel, t_off;
   logic [3:0]          words;
   logic [5:0]          tstart;
   logic                allow;
   result_type          pay_res, sum_res, push0, push1;
   logic                push0_en, push1_en;
   logic [2:0]          n_push;

   assign b          = req_tdata;
   assign req_tready = (count_ff <= 3'd2);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != 3'd0);
   assign pop        = rsp_tvalid && rsp_tready;

   // IHL below five counts as five for the transport start
   assign words  = (ihl_ff < 4'd5) ? 4'd5 : ihl_ff;
   assign tstart = {words, 2'b00};

   // capture logic for one byte
   always_comb begin
      eth_type_in  = eth_type_ff;
      pppoe_code_in = pppoe_code_ff;
      pppoe_ses_in = pppoe_ses_ff;
      ppp_proto_in = ppp_proto_ff;
      ihl_in       = ihl_ff;
      ip_proto_in  = ip_proto_ff;
      src_ip_in    = src_ip_ff;
      dst_ip_in    = dst_ip_ff;
      ports_in     = ports_ff;
      flags_in     = flags_ff;
      phase_in     = phase_ff;
      offset_in    = offset_ff;
      emit         = 1'b0;
      ip_ok        = 1'b0;
      base         = IP_BASE_ETH;
      rel          = '0;
      t_off        = '0;
      allow        = 1'b0;

      if (offset_ff < OFFSET_W'(MAX_FRAME_BYTES)) begin
         // Ethernet type
         if (offset_ff == 16'd12) begin
            eth_type_in = {b, 8'h00};
         end else if (offset_ff == 16'd13) begin
            eth_type_in = {eth_type_ff[15:8], eth_type_ff[7:0] | b};
         end

         // PPPoE header and PPP protocol
         if (eth_type_in == ETYPE_PPPOE_SES && offset_ff >= 16'd14) begin
            priority if (offset_ff == 16'd15) begin
               pppoe_code_in = b;
            end else if (offset_ff == 16'd16) begin
               pppoe_ses_in = {b, 8'h00};
            end else if (offset_ff == 16'd17) begin
               pppoe_ses_in = {pppoe_ses_ff[15:8], pppoe_ses_ff[7:0] | b};
            end else if (pppoe_code_in == PPPOE_CODE_SES && offset_ff == 16'd20) begin
               ppp_proto_in = {b, 8'h00};
            end else if (pppoe_code_in == PPPOE_CODE_SES && offset_ff == 16'd21) begin
               ppp_proto_in = {ppp_proto_ff[15:8], ppp_proto_ff[7:0] | b};
            end else begin
               // other PPPoE bytes carry nothing we keep
            end
         end

         // where the IPv4 header starts
         if (eth_type_in == ETYPE_IPV4) begin
            ip_ok = 1'b1;
            base  = IP_BASE_ETH;
         end else if (eth_type_in == ETYPE_PPPOE_SES && pppoe_code_in == PPPOE_CODE_SES &&
                      ppp_proto_in == PPP_PROTO_IPV4) begin
            ip_ok = 1'b1;
            base  = IP_BASE_PPPOE;
         end
         rel   = offset_ff - base;
         t_off = rel - OFFSET_W'(tstart);
         allow = (eth_type_in == ETYPE_PPPOE_SES) || extract_mode_ff;

         // IPv4 header and transport header
         if (ip_ok && offset_ff >= base) begin
            priority if (rel == 16'd0) begin
               ihl_in = b[3:0];
            end else if (rel == 16'd9) begin
               ip_proto_in = {1'b0, b};
            end else if (rel >= 16'd12 && rel < 16'd16) begin
               src_ip_in = {src_ip_ff[23:0], b};
            end else if (rel >= 16'd16 && rel < 16'd20) begin
               dst_ip_in = {dst_ip_ff[23:0], b};
            end else if (rel >= OFFSET_W'(tstart) &&
                         (ip_proto_ff == IP_PROTO_TCP || ip_proto_ff == IP_PROTO_UDP)) begin
               if (t_off < 16'd4) begin
                  ports_in = {ports_ff[23:0], b};
               end
               if (ip_proto_ff == IP_PROTO_TCP) begin
                  if (t_off == 16'd13) begin
                     flags_in = b[5:0] & TCP_FLAG_MASK[5:0];
                  end
               end else if (phase_ff == PH_STREAM) begin
                  emit = 1'b1;
               end else if (phase_ff == PH_WAIT && t_off == 16'd8) begin
                  if (b == RTP_V2_BYTE) begin
                     phase_in = PH_RTP;
                  end else if (b == TS_SYNC_BYTE && allow) begin
                     phase_in = PH_STREAM;
                     emit     = 1'b1;
                  end else begin
                     phase_in = PH_NONE;
                  end
               end else if (phase_ff == PH_RTP && t_off == 16'd20) begin
                  if (b == TS_SYNC_BYTE && allow) begin
                     phase_in = PH_STREAM;
                     emit     = 1'b1;
                  end else begin
                     phase_in = PH_NONE;
                  end
               end
            end else begin
               // header bytes that are not captured
            end
         end
         offset_in = offset_ff + 16'd1;
      end
   end

   // result words built from this byte
   always_comb begin
      pay_res              = '0;
      pay_res.kind         = KIND_PAYLOAD;
      pay_res.last_of_run  = !req_tlast;
      pay_res.payload_byte = b;

      sum_res               = '0;
      sum_res.kind          = KIND_SUMMARY;
      sum_res.last_of_run   = 1'b1;
      sum_res.ether_type    = eth_type_in;
      sum_res.pppoe_code    = pppoe_code_in;
      sum_res.pppoe_session = pppoe_ses_in;
      sum_res.ip_protocol   = ip_proto_in;
      sum_res.src_ip        = src_ip_in;
      sum_res.dst_ip        = dst_ip_in;
      sum_res.src_port      = ports_in[31:16];
      sum_res.dst_port      = ports_in[15:0];
      sum_res.ctrl_flags    = flags_in;

      push0    = emit ? pay_res : sum_res;
      push1    = sum_res;
      push0_en = accept && (emit || req_tlast);
      push1_en = accept && emit && req_tlast;
      n_push   = {2'b00, push0_en} + {2'b00, push1_en};
   end

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff + n_push[1:0];
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + n_push - {2'b00, pop};
   end

   // control and frame registers
   always_ff @(posedge clock) begin
      if (reset) begin
         extract_mode_ff <= 1'b0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         count_ff        <= '0;
         offset_ff       <= '0;
         eth_type_ff     <= '0;
         pppoe_code_ff   <= '0;
         pppoe_ses_ff    <= '0;
         ppp_proto_ff    <= '0;
         ihl_ff          <= '0;
         ip_proto_ff     <= IP_PROTO_NONE;
         src_ip_ff       <= '0;
         dst_ip_ff       <= '0;
         ports_ff        <= '0;
         flags_ff        <= '0;
         phase_ff        <= PH_WAIT;
      end else begin
         if (csr_wr_en) begin
            extract_mode_ff <= csr_wr_data;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         if (accept) begin
            if (req_tlast) begin
               // end of frame: back to the reset picture
               offset_ff     <= '0;
               eth_type_ff   <= '0;
               pppoe_code_ff <= '0;
               pppoe_ses_ff  <= '0;
               ppp_proto_ff  <= '0;
               ihl_ff        <= '0;
               ip_proto_ff   <= IP_PROTO_NONE;
               src_ip_ff     <= '0;
               dst_ip_ff     <= '0;
               ports_ff      <= '0;
               flags_ff      <= '0;
               phase_ff      <= PH_WAIT;
            end else begin
               offset_ff     <= offset_in;
               eth_type_ff   <= eth_type_in;
               pppoe_code_ff <= pppoe_code_in;
               pppoe_ses_ff  <= pppoe_ses_in;
               ppp_proto_ff  <= ppp_proto_in;
               ihl_ff        <= ihl_in;
               ip_proto_ff   <= ip_proto_in;
               src_ip_ff     <= src_ip_in;
               dst_ip_ff     <= dst_ip_in;
               ports_ff      <= ports_in;
               flags_ff      <= flags_in;
               phase_ff      <= phase_in;
            end
         end
      end
   end

   // queue storage, up to two writes a cycle
   always_ff @(posedge clock) begin
      if (push0_en) begin
         queue_ff[wr_ptr_ff] <= push0;
      end
      if (push1_en) begin
         queue_ff[wr_ptr_ff + 2'd1] <= push1;
      end
   end

   // head of queue onto the result port
   result_type head;
   assign head      = queue_ff[rd_ptr_ff];
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last_of_run;
   assign rsp_tdata = {1'b0, head.ctrl_flags, head.dst_port, head.src_port, head.dst_ip,
                       head.src_ip, head.ip_protocol, head.pppoe_session, head.pppoe_code,
                       head.ether_type, head.payload_byte};

endmodule

FILE: tb/tb.sv
// Testbench for eth_pppoe_ip_header_parser: drives whole frames byte by byte,
// predicts every payload and summary word in a shadow parser and checks them.
// Depends on eppip_pkg and the parser RTL only.
`timescale 1ns / 100ps

module tb;
   import eppip_pkg::*;

   // Worst case is about 2.1k bytes, each with a sender gap and two words each
   // waiting out a long stall, plus one long hold; the limit is several times
   // that.
   localparam int unsigned LIMIT_CYCLES = 1_000_000;
   localparam int          RAND_ITEMS   = 830;
   localparam int          FLAT_W       = RSP_DATA_W + 2;
   localparam int          NUM_FIELDS   = 12;
   localparam int          MAX_REPORTS  = 40;
   localparam int          HOLD_CYCLES  = 400;

   typedef enum {ENC_RAW, ENC_ETH, ENC_PPPOE, ENC_PPPOE_CTL, ENC_PPPOE_NONIP} encap_type;
   typedef enum {L4_TCP, L4_UDP, L4_OTHER} l4_type;
   typedef enum {FILL_RAND, FILL_ZERO, FILL_ONES} fill_type;

   // one frame to send; x_etype / x_proto give a hand-written summary when chk is set
   typedef struct {
      encap_type   encap;
      l4_type      l4;
      logic [3:0]  ihl;
      logic        rtp;
      logic        sync;
      fill_type    fill;
      int          pay_len;
      int          cut;
      logic        mode;
      logic        hold;
      logic        chk;
      logic [15:0] x_etype;
      logic [8:0]  x_proto;
   } frame_spec_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata   = 8'h00;
   logic                  req_tlast   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_wr_en   = 1'b0;
   logic                  csr_wr_data = 1'b0;

   // shadow copy of the parser state
   logic        sh_mode;
   int unsigned sh_offset;
   logic [15:0] sh_etype;
   logic [7:0]  sh_code;
   logic [15:0] sh_session;
   logic [15:0] sh_ppp;
   logic [3:0]  sh_ihl;
   logic [8:0]  sh_proto;
   logic [31:0] sh_src;
   logic [31:0] sh_dst;
   logic [31:0] sh_ports;
   logic [5:0]  sh_flags;
   logic [1:0]  sh_phase;

   result_type  due_words [$];   // result words predicted but not yet seen
   logic [7:0]  frame_q [$];     // bytes of the frame being sent
   int          err_count   = 0;
   int unsigned cycle_count = 0;
   logic        tx_calm     = 1'b0;
   logic        hold_go     = 1'b0;

   // result fields in {tdata, tlast, tuser} order, lowest bit first
   string fld_name [NUM_FIELDS] = '{"kind", "last_of_run", "payload_byte", "ether_type",
      "pppoe_code", "pppoe_session", "ip_protocol", "src_ip", "dst_ip", "src_port",
      "dst_port", "ctrl_flags"};
   int fld_lo [NUM_FIELDS] = '{0, 1, 2, 10, 26, 34, 50, 59, 91, 123, 139, 155};
   int fld_w  [NUM_FIELDS] = '{1, 1, 8, 16, 8, 16, 9, 32, 32, 16, 16, 6};

   // directed frames
   // encap, l4, ihl, rtp, sync, fill, pay_len, cut, mode, hold, chk, x_etype, x_proto
   frame_spec_type plan [18] = '{
      '{ENC_RAW, L4_UDP, 4'd5, 1'b0, 1'b0, FILL_ZERO, 1, 0, 1'b0, 1'b0, 1'b1,
        16'h0000, IP_PROTO_NONE},
      '{ENC_RAW, L4_UDP, 4'd5, 1'b0, 1'b0, FILL_ONES, 64, 0, 1'b0, 1'b0, 1'b1,
        16'hFFFF, IP_PROTO_NONE},
      '{ENC_ETH, L4_UDP, 4'd5, 1'b0, 1'b1, FILL_ZERO, 0, 14, 1'b0, 1'b0, 1'b1,
        ETYPE_IPV4, IP_PROTO_NONE},
      '{ENC_ETH, L4_UDP, 4'd5, 1'b0, 1'b1, FILL_RAND, 30, 0, 1'b0, 1'b0, 1'b0,
        16'h0, 9'h0},
      '{ENC_PPPOE, L4_UDP, 4'd5, 1'b0, 1'b1, FILL_RAND, 40, 0, 1'b0, 1'b1, 1'b0,
        16'h0, 9'h0},
      '{ENC_PPPOE, L4_UDP, 4'd5, 1'b1, 1'b1, FILL_RAND, 24, 0, 1'b0, 1'b0, 1'b0,
        16'h0, 9'h0},
      '{ENC_PPPOE, L4_UDP, 4'd5, 1'b1, 1'b0, FILL_RAND, 16, 0, 1'b0, 1'b0, 1'b0,
        16'h0, 9'h0},
      '{ENC_PPPOE, L4_UDP, 4'd5, 1'b0, 1'b0, FILL_RAND, 16, 0, 1'b0, 1'b0, 1'b0,
        16'h0, 9'h0},
      '{ENC_PPPOE_CTL, L4_UDP, 4'd5, 1'b0, 1'b1, FILL_RAND, 16, 0, 1'b0, 1'b0, 1'b0,
        16'h0, 9'h0},
      '{ENC_PPPOE_NONIP, L4_UDP, 4'd5, 1'b0, 1'b1, FILL_RAND, 16, 0, 1'b0, 1'b0, 1'b0,
        16'h0, 9'h0},
      '{ENC_ETH, L4_TCP, 4'd7, 1'b0, 1'b0, FILL_RAND, 10, 0, 1'b1, 1'b0, 1'b0,
        16'h0, 9'h0},
      '{ENC_ETH, L4_UDP, 4'd2, 1'b0, 1'b1, FILL_RAND, 20, 0, 1'b1, 1'b0, 1'b0,
        16'h0, 9'h0},
      '{ENC_ETH, L4_UDP, 4'd15, 1'b1, 1'b1, FILL_RAND, 20, 0, 1'b1, 1'b0, 1'b0,
        16'h0, 9'h0},
      '{ENC_ETH, L4_OTHER, 4'd5, 1'b0, 1'b0, FILL_RAND, 10, 0, 1'b1, 1'b0, 1'b0,
        16'h0, 9'h0},
      '{ENC_PPPOE, L4_TCP, 4'd5, 1'b0, 1'b0, FILL_ONES, 5, 0, 1'b1, 1'b0, 1'b0,
        16'h0, 9'h0},
      '{ENC_ETH, L4_UDP, 4'd5, 1'b0, 1'b1, FILL_ONES, 8, 0, 1'b1, 1'b0, 1'b0,
        16'h0, 9'h0},
      '{ENC_ETH, L4_TCP, 4'd5, 1'b0, 1'b0, FILL_RAND, 0, 40, 1'b0, 1'b0, 1'b0,
        16'h0, 9'h0},
      '{ENC_ETH, L4_UDP, 4'd5, 1'b0, 1'b1, FILL_ZERO, 4, 0, 1'b0, 1'b0, 1'b0,
        16'h0, 9'h0}
   };

   eth_pppoe_ip_header_parser u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // frame state back to its idle values
   function automatic void clear_shadow();
      sh_offset  = 0;
      sh_etype   = '0;
      sh_code    = '0;
      sh_session = '0;
      sh_ppp     = '0;
      sh_ihl     = '0;
      sh_proto   = IP_PROTO_NONE;
      sh_src     = '0;
      sh_dst     = '0;
      sh_ports   = '0;
      sh_flags   = '0;
      sh_phase   = PH_WAIT;
   endfunction

   // shadow parser: one accepted byte in, due result words out
   task automatic parse_byte(input logic [7:0] b, input logic last,
                             input logic use_typed, input result_type typed_sum);
      int unsigned off, base, rel, tpos, t;
      logic        ip_ok, allow, emit;
      result_type  w;
      off   = sh_offset;
      emit  = 1'b0;
      ip_ok = 1'b0;
      base  = 0;
      if (off < MAX_FRAME_BYTES) begin
         if (off == 12) sh_etype = {b, 8'h00};
         else if (off == 13) sh_etype = sh_etype | {8'h00, b};

         // PPPoE code and session for any code, PPP protocol for session data
         if (sh_etype == ETYPE_PPPOE_SES && off >= 14) begin
            if (off == 15) sh_code = b;
            else if (off == 16) sh_session = {b, 8'h00};
            else if (off == 17) sh_session = sh_session | {8'h00, b};
            else if (sh_code == PPPOE_CODE_SES && off == 20) sh_ppp = {b, 8'h00};
            else if (sh_code == PPPOE_CODE_SES && off == 21) sh_ppp = sh_ppp | {8'h00, b};
         end

         if (sh_etype == ETYPE_IPV4) begin
            ip_ok = 1'b1;
            base  = IP_BASE_ETH;
         end else if (sh_etype == ETYPE_PPPOE_SES && sh_code == PPPOE_CODE_SES &&
                      sh_ppp == PPP_PROTO_IPV4) begin
            ip_ok = 1'b1;
            base  = IP_BASE_PPPOE;
         end

         if (ip_ok && off >= base) begin
            rel  = off - base;
            tpos = (sh_ihl < 5) ? 20 : 4 * sh_ihl;   // short IHL counts as five words
            if (rel == 0) sh_ihl = b[3:0];
            else if (rel == 9) sh_proto = {1'b0, b};
            else if (rel >= 12 && rel < 16) sh_src = {sh_src[23:0], b};
            else if (rel >= 16 && rel < 20) sh_dst = {sh_dst[23:0], b};
            else if (rel >= tpos && (sh_proto == IP_PROTO_TCP || sh_proto == IP_PROTO_UDP))
            begin
               t     = rel - tpos;
               allow = (sh_etype == ETYPE_PPPOE_SES) || sh_mode;
               if (t < 4) sh_ports = {sh_ports[23:0], b};
               if (sh_proto == IP_PROTO_TCP) begin
                  if (t == 13) sh_flags = 6'(b & TCP_FLAG_MASK);
               end else if (sh_phase == PH_STREAM) begin
                  emit = 1'b1;
               end else if (sh_phase == PH_WAIT && t == 8) begin
                  if (b == RTP_V2_BYTE) sh_phase = PH_RTP;
                  else if (b == TS_SYNC_BYTE && allow) begin
                     sh_phase = PH_STREAM;
                     emit     = 1'b1;
                  end else sh_phase = PH_NONE;
               end else if (sh_phase == PH_RTP && t == 20) begin
                  if (b == TS_SYNC_BYTE && allow) begin
                     sh_phase = PH_STREAM;
                     emit     = 1'b1;
                  end else sh_phase = PH_NONE;
               end
            end
         end
         sh_offset = off + 1;
      end

      if (emit) begin
         w              = '0;
         w.kind         = KIND_PAYLOAD;
         w.last_of_run  = !last;
         w.payload_byte = b;
         due_words.push_back(w);
      end
      // summary goes after the payload word of the same byte
      if (last) begin
         if (use_typed) w = typed_sum;
         else begin
            w               = '0;
            w.kind          = KIND_SUMMARY;
            w.last_of_run   = 1'b1;
            w.ether_type    = sh_etype;
            w.pppoe_code    = sh_code;
            w.pppoe_session = sh_session;
            w.ip_protocol   = sh_proto;
            w.src_ip        = sh_src;
            w.dst_ip        = sh_dst;
            w.src_port      = sh_ports[31:16];
            w.dst_port      = sh_ports[15:0];
            w.ctrl_flags    = sh_flags;
         end
         due_words.push_back(w);
         clear_shadow();
      end
   endtask

   function automatic void set_byte(input int idx, input logic [7:0] v);
      if (idx < frame_q.size()) frame_q[idx] = v;
   endfunction

   // lay out one frame into frame_q
   function automatic void build_frame(input frame_spec_type s);
      int          base, tpos, total, cpos, r;
      logic [7:0]  fb;
      logic [15:0] ppp;
      base = (s.encap == ENC_ETH) ? 14 : 22;
      tpos = base + ((s.ihl < 5) ? 20 : 4 * s.ihl);
      case (s.l4)
         L4_TCP:  total = tpos + 20;
         L4_UDP:  total = tpos + (s.rtp ? 21 : 9);
         default: total = tpos + 8;
      endcase
      total = total + s.pay_len;
      if (s.encap == ENC_RAW) total = s.pay_len;
      if (s.cut > 0) total = s.cut;
      if (total < 1) total = 1;

      frame_q.delete();
      for (int i = 0; i < total; i++) begin
         case (s.fill)
            FILL_ZERO: fb = 8'h00;
            FILL_ONES: fb = 8'hFF;
            default:   fb = 8'($urandom);
         endcase
         frame_q.push_back(fb);
      end
      if (s.encap == ENC_RAW) return;

      // link layer
      if (s.encap == ENC_ETH) begin
         set_byte(12, ETYPE_IPV4[15:8]);
         set_byte(13, ETYPE_IPV4[7:0]);
      end else begin
         r   = $urandom_range(0, 2);
         ppp = (r == 0) ? 16'hC021 : (r == 1) ? 16'h2100 : 16'h0057;
         if (s.encap != ENC_PPPOE_NONIP) ppp = PPP_PROTO_IPV4;
         set_byte(12, ETYPE_PPPOE_SES[15:8]);
         set_byte(13, ETYPE_PPPOE_SES[7:0]);
         set_byte(14, 8'h11);
         set_byte(15, (s.encap == ENC_PPPOE_CTL) ? 8'($urandom_range(1, 255)) : PPPOE_CODE_SES);
         set_byte(20, ppp[15:8]);
         set_byte(21, ppp[7:0]);
      end

      // IPv4 and transport header
      set_byte(base, {4'h4, s.ihl});
      case (s.l4)
         L4_TCP:  set_byte(base + 9, IP_PROTO_TCP[7:0]);
         L4_UDP:  set_byte(base + 9, IP_PROTO_UDP[7:0]);
         default: set_byte(base + 9, 8'($urandom_range(8'h12, 8'hFF)));
      endcase
      if (s.l4 == L4_UDP) begin
         cpos = tpos + 8;
         if (s.rtp) begin
            set_byte(cpos, RTP_V2_BYTE);
            cpos = tpos + 20;
         end
         set_byte(cpos, s.sync ? TS_SYNC_BYTE : 8'($urandom_range(0, 8'h46)));
      end
   endfunction

   function automatic frame_spec_type random_spec();
      frame_spec_type s;
      int             r;
      s.fill    = FILL_RAND;
      s.hold    = 1'b0;
      s.chk     = 1'b0;
      s.x_etype = '0;
      s.x_proto = '0;
      s.mode    = ($urandom_range(0, 7) == 0) ? !sh_mode : sh_mode;
      s.ihl     = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd5;
      s.rtp     = 1'($urandom_range(0, 1));
      r         = $urandom_range(0, 99);
      s.l4      = (r < 60) ? L4_UDP : (r < 90) ? L4_TCP : L4_OTHER;
      r         = $urandom_range(0, 99);
      if (r < 80) begin
         // well-formed headers, random content
         s.encap   = $urandom_range(0, 1) ? ENC_ETH : ENC_PPPOE;
         s.sync    = ($urandom_range(0, 9) != 0);
         s.pay_len = $urandom_range(0, 24);
         s.cut     = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : 0;
      end else begin
         // noise and broken frames
         r         = $urandom_range(0, 3);
         s.encap   = (r == 0) ? ENC_RAW : (r == 1) ? ENC_PPPOE_CTL :
                     (r == 2) ? ENC_PPPOE_NONIP : ENC_ETH;
         s.sync    = 1'($urandom_range(0, 1));
         s.pay_len = $urandom_range(1, 40);
         s.cut     = $urandom_range(0, 1) ? $urandom_range(1, 80) : 0;
      end
      return s;
   endfunction

   function automatic int pick_gap();
      int r;
      if (tx_calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // offer one byte from a falling edge, return at a falling edge after any gap
   task automatic send_byte(input logic [7:0] b, input logic last,
                            input logic use_typed, input result_type typed_sum);
      int gap;
      req_tvalid = 1'b1;
      req_tdata  = b;
      req_tlast  = last;
      do @(posedge clock); while (!req_tready);
      parse_byte(b, last, use_typed, typed_sum);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // stop sending until every due word is out and the pipe has settled
   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (due_words.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_mode(input logic m);
      wait_idle();
      csr_wr_en   = 1'b1;
      csr_wr_data = m;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      sh_mode     = m;
   endtask

   task automatic run_frame(input frame_spec_type s);
      result_type typed;
      if (s.mode != sh_mode) write_mode(s.mode);
      build_frame(s);
      typed             = '0;
      typed.kind        = KIND_SUMMARY;
      typed.last_of_run = 1'b1;
      typed.ether_type  = s.x_etype;
      typed.ip_protocol = s.x_proto;
      tx_calm = ($urandom_range(0, 3) == 0);
      if (s.hold) hold_go = 1'b1;
      for (int i = 0; i < frame_q.size(); i++)
         send_byte(frame_q[i], i == frame_q.size() - 1, s.chk, typed);
   endtask

   function automatic logic [FLAT_W-1:0] flatten(input result_type w);
      return {1'b0, w.ctrl_flags, w.dst_port, w.src_port, w.dst_ip, w.src_ip, w.ip_protocol,
              w.pppoe_session, w.pppoe_code, w.ether_type, w.payload_byte, w.last_of_run,
              w.kind};
   endfunction

   function automatic logic [31:0] field_of(input logic [FLAT_W-1:0] v, input int lo,
                                            input int w);
      logic [FLAT_W-1:0] s;
      s = v >> lo;
      return s[31:0] & 32'((33'h1 << w) - 1);
   endfunction

   // receiver: random stalls, calm stretches, and a long hold when asked
   always @(negedge clock) begin
      static int hold_left    = 0;
      static int stall_left   = 0;
      static int rx_calm_left = 0;
      int r;
      if (hold_go) begin
         hold_go   = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready = 1'b0;
      end else if (rx_calm_left > 0) begin
         rx_calm_left--;
         rsp_tready = 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 3) begin
            rx_calm_left = $urandom_range(50, 200);
            rsp_tready   = 1'b1;
         end else if (r < 70) rsp_tready = 1'b1;
         else if (r < 95) begin
            rsp_tready = 1'b0;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_tready = 1'b0;
            stall_left = $urandom_range(10, 30);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      logic [FLAT_W-1:0] got, want;
      logic [31:0]       gv, wv;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata, rsp_tlast, rsp_tuser};
         if (due_words.size() == 0) begin
            if (err_count < MAX_REPORTS) $error("result word with nothing due: 0x%0h", got);
            err_count++;
         end else begin
            want = flatten(due_words.pop_front());
            for (int i = 0; i < NUM_FIELDS; i++) begin
               gv = field_of(got, fld_lo[i], fld_w[i]);
               wv = field_of(want, fld_lo[i], fld_w[i]);
               if (gv !== wv) begin
                  if (err_count < MAX_REPORTS)
                     $error("%s mismatch: expected 0x%0h, got 0x%0h", fld_name[i], wv, gv);
                  err_count++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      frame_spec_type s;
      int             rand_items;
      sh_mode = 1'b0;
      clear_shadow();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) run_frame(plan[i]);

      rand_items = 0;
      while (rand_items < RAND_ITEMS) begin
         s = random_spec();
         run_frame(s);
         rand_items += frame_q.size();
      end

      wait_idle();
      if (err_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
